FILE: sv/temporal_frame_bin_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for temporal_frame_bin_average
// Shared implication checks, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_FRAME_BIN_AVERAGE_DEFINES_SVH
`define TEMPORAL_FRAME_BIN_AVERAGE_DEFINES_SVH

// same-cycle implication
`define TFBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tfba_pkg.sv
// ----------------------------------------------------------------------------
// tfba_pkg
// Types, constants and byte-order helper for temporal_frame_bin_average.
// ----------------------------------------------------------------------------
`default_nettype none

package tfba_pkg;

    localparam int PIX_W = 32;
    localparam int SUM_W = 48;
    localparam int PPF_W = 17;
    localparam int FPB_W = 16;
    localparam int CFG_W = 17;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PPF  = 3'd0;
    localparam t_cfg_idx CFG_FPB  = 3'd1;
    localparam t_cfg_idx CFG_MODE = 3'd2;
    localparam t_cfg_idx CFG_BIG  = 3'd3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_1B  = 2'd0;
    localparam t_mode MODE_2B  = 2'd1;
    localparam t_mode MODE_4B  = 2'd2;
    localparam t_mode MODE_BAD = 2'd3;

    // file order <-> numeric value; its own inverse
    function automatic logic [PIX_W-1:0] reorder(input logic [PIX_W-1:0] w,
                                                 input t_mode mode,
                                                 input logic big);
        logic [PIX_W-1:0] r;
        case (mode)
            MODE_1B: r = {24'h0, w[7:0]};
            MODE_2B: r = big ? {16'h0, w[7:0], w[15:8]} : {16'h0, w[15:0]};
            default: r = big ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tfba_in_if.sv
// ----------------------------------------------------------------------------
// tfba_in_if
// Input pixel channel: valid/ready with one raw pixel word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfba_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

`default_nettype wire

FILE: sv/tfba_out_if.sv
// ----------------------------------------------------------------------------
// tfba_out_if
// Result channel: valid/ready with averaged pixel and frame end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfba_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] averaged_pixel;
    logic        frame_end;

    modport source (output valid, output averaged_pixel, output frame_end, input ready);
    modport sink   (input valid, input averaged_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: sv/temporal_frame_bin_average.sv
// ----------------------------------------------------------------------------
// temporal_frame_bin_average
// Temporal binning of a raw pixel stream into averaged frames.
// ----------------------------------------------------------------------------
// After reset the sum memory is cleared, one entry per cycle, and no pixel
// is taken until that ends. A pixel then goes through the back end as a
// sum memory read, add and write back; on the last frame of a bin it goes
// through read, add, 48 steps of the bit-serial 48/16 divider and result
// load. A two-entry queue lets the front take pixels while the back works,
// and the result register lets the back go on while a result waits.
`default_nettype none

module temporal_frame_bin_average #(
    parameter int          MAX_PIXELS     = 65536,
    parameter logic [31:0] MAX_BIN_FRAMES = 32'd65535
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire tfba_pkg::t_cfg_idx          i_cfg_index,
    input  wire logic [tfba_pkg::CFG_W-1:0]  i_cfg_data,
    tfba_in_if.sink                          i_in,
    tfba_out_if.source                       o_out
);
    import tfba_pkg::*;

    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int ENT_W = PW + 34;

    logic [PPF_W-1:0] r_ppf;
    logic [FPB_W-1:0] r_fpb;
    t_mode            r_mode;
    logic             r_big;

    logic             push, pop, full, empty, clearing;
    logic [ENT_W-1:0] entry, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppf  <= 17'd1;
            r_fpb  <= 16'd1;
            r_mode <= MODE_1B;
            r_big  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PPF:  r_ppf  <= i_cfg_data;
                CFG_FPB:  r_fpb  <= i_cfg_data[FPB_W-1:0];
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                CFG_BIG:  r_big  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tfba_front #(.MAX_PIXELS(MAX_PIXELS), .MAX_BIN_FRAMES(MAX_BIN_FRAMES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ppf   (r_ppf),
        .i_fpb   (r_fpb),
        .i_mode  (r_mode),
        .i_big   (r_big),
        .i_hold  (clearing),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    tfba_queue #(.WIDTH(ENT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    tfba_back #(.MAX_PIXELS(MAX_PIXELS), .MAX_BIN_FRAMES(MAX_BIN_FRAMES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_fpb      (r_fpb),
        .i_mode     (r_mode),
        .i_big      (r_big),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

FILE: sv/tfba_ram.sv
// ----------------------------------------------------------------------------
// tfba_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tfba_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tfba_queue.sv
// ----------------------------------------------------------------------------
// tfba_queue
// Two-entry FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tfba_queue #(
    parameter int WIDTH = 50
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 2'd1;
        if (do_pop && !do_push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
        end
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

`default_nettype wire

FILE: sv/tfba_front.sv
// ----------------------------------------------------------------------------
// tfba_front
// Accepts pixels, decodes byte order, tracks position and frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module tfba_front #(
    parameter int          MAX_PIXELS     = 65536,
    parameter logic [31:0] MAX_BIN_FRAMES = 32'd65535,
    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int ENT_W = PW + 34
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tfba_in_if.sink                          i_in,
    input  wire logic [tfba_pkg::PPF_W-1:0]  i_ppf,
    input  wire logic [tfba_pkg::FPB_W-1:0]  i_fpb,
    input  wire tfba_pkg::t_mode             i_mode,
    input  wire logic                        i_big,
    input  wire logic                        i_hold,
    input  wire logic                        i_full,
    output logic                             o_push,
    output logic      [ENT_W-1:0]            o_entry
);
    import tfba_pkg::*;

    logic [PW-1:0]    r_pos, n_pos;
    logic [FPB_W-1:0] r_frames, n_frames;
    logic [31:0]      ppf_c, last32;
    logic [PW-1:0]    last_idx, pos_c;
    logic [FPB_W-1:0] fpb_c;
    logic [FPB_W:0]   frames_inc;
    logic             last_pixel, last_frame, accept;
    logic [PIX_W-1:0] value;

    assign i_in.ready = !i_full && !i_hold;
    assign accept     = i_in.valid && i_in.ready && (i_mode != MODE_BAD);

    always_comb begin
        ppf_c = {15'h0, i_ppf};
        if (ppf_c == 32'd0) ppf_c = 32'd1;
        if (ppf_c > 32'(MAX_PIXELS)) ppf_c = 32'(MAX_PIXELS);
        last32   = ppf_c - 32'd1;
        last_idx = last32[PW-1:0];
        pos_c    = (r_pos > last_idx) ? last_idx : r_pos;
        fpb_c = i_fpb;
        if ({16'h0, fpb_c} > MAX_BIN_FRAMES) fpb_c = MAX_BIN_FRAMES[FPB_W-1:0];
        if (fpb_c == '0) fpb_c = 16'd1;
        frames_inc = {1'b0, r_frames} + 17'd1;
        last_pixel = (pos_c == last_idx);
        last_frame = (frames_inc >= {1'b0, fpb_c});
        value      = reorder(i_in.raw_pixel, i_mode, i_big);
        n_pos      = r_pos;
        n_frames   = r_frames;
        if (accept) begin
            if (last_pixel) begin
                n_pos    = '0;
                n_frames = last_frame ? '0 : frames_inc[FPB_W-1:0];
            end else begin
                n_pos = pos_c + PW'(1);
            end
        end
    end

    assign o_push  = accept;
    assign o_entry = {pos_c, value, last_pixel, last_frame};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_frames <= '0;
        end else begin
            r_pos    <= n_pos;
            r_frames <= n_frames;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tfba_back.sv
// ----------------------------------------------------------------------------
// tfba_back
// Read-modify-write of pixel sums, serial divide, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "temporal_frame_bin_average_defines.svh"

module tfba_back #(
    parameter int          MAX_PIXELS     = 65536,
    parameter logic [31:0] MAX_BIN_FRAMES = 32'd65535,
    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int ENT_W = PW + 34
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ENT_W-1:0]            i_head,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    input  wire logic [tfba_pkg::FPB_W-1:0]  i_fpb,
    input  wire tfba_pkg::t_mode             i_mode,
    input  wire logic                        i_big,
    output logic                             o_clearing,
    tfba_out_if.source                       o_out
);
    import tfba_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ADD, S_DIV, S_OUT} t_state;

    t_state           r_state;
    logic [PW-1:0]    r_addr;
    logic [PW-1:0]    r_pos;
    logic [PIX_W-1:0] r_val;
    logic             r_lp, r_lf;
    logic [FPB_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [5:0]       r_cnt;
    logic             r_out_valid, r_out_end;
    logic [PIX_W-1:0] r_out_data;

    logic             we;
    logic [PW-1:0]    waddr;
    logic [SUM_W-1:0] wdata, rdata, sum;
    logic [FPB_W-1:0] fpb_c;
    logic [FPB_W:0]   rem_sh, rem_sub;
    logic             qbit;

    tfba_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_head[ENT_W-1 -: PW]),
        .o_rdata (rdata)
    );

    always_comb begin
        fpb_c = i_fpb;
        if ({16'h0, fpb_c} > MAX_BIN_FRAMES) fpb_c = MAX_BIN_FRAMES[FPB_W-1:0];
        if (fpb_c == '0) fpb_c = 16'd1;
        sum     = rdata + {16'h0, r_val};
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, fpb_c};
        qbit    = (rem_sh >= {1'b0, fpb_c});
        we    = 1'b0;
        waddr = r_pos;
        wdata = '0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_addr;
            end
            S_ADD: begin
                we    = 1'b1;
                wdata = r_lf ? '0 : sum;
            end
            default: ;
        endcase
    end

    assign o_pop              = (r_state == S_IDLE) && !i_empty;
    assign o_clearing         = (r_state == S_CLEAR);
    assign o_out.valid        = r_out_valid;
    assign o_out.averaged_pixel = r_out_data;
    assign o_out.frame_end    = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + PW'(1);
                    if (r_addr == PW'(MAX_PIXELS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        {r_pos, r_val, r_lp, r_lf} <= i_head;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_quo   <= sum;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= r_lf ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_rem <= qbit ? rem_sub[FPB_W-1:0] : rem_sh[FPB_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], qbit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(SUM_W - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= reorder(r_quo[PIX_W-1:0], i_mode, i_big);
                        r_out_end   <= r_lp;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TFBA_ASSERT_IMP(a_clear_no_pop, r_state == S_CLEAR, !o_pop && we && wdata == '0, "pop during clear")
    `TFBA_ASSERT_IMP(a_div_count, r_state == S_DIV, r_cnt < 6'(SUM_W), "divide overrun")
    `TFBA_ASSERT_NXT(a_out_load, r_state == S_OUT && !r_out_valid, r_out_valid && r_state == S_IDLE, "result not loaded")
    `TFBA_ASSERT_NXT(a_add_after_pop, o_pop, r_state == S_ADD, "pop without add")

endmodule

`default_nettype wire
